@@ rtl/acmac_pkg.sv @@
// Shared types, codes and AES helper functions for the CMAC tag core.
`default_nettype none
package acmac_pkg;

  localparam int BLK_W = 128;
  localparam int TAG_W = 32;

  // command kinds passed from front to back
  localparam logic [1:0] CMD_CBC = 2'd0;
  localparam logic [1:0] CMD_K1  = 2'd1;
  localparam logic [1:0] CMD_K2  = 2'd2;

  // configuration register indexes
  localparam logic CFG_KEY_HIGH = 1'b0;
  localparam logic CFG_KEY_LOW  = 1'b1;

  typedef struct packed {
    logic [1:0]       kind;
    logic             fresh;
    logic [BLK_W-1:0] blk;
  } cmd_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  function automatic logic [7:0] xt(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  // one AES round without the round key; fin skips MixColumns
  function automatic logic [127:0] aes_round(input logic [127:0] s, input logic fin);
    logic [7:0]   t [16];
    logic [127:0] o;
    logic [7:0]   a0, a1, a2, a3, al;
    for (int c = 0; c < 4; c++)
      for (int j = 0; j < 4; j++)
        t[c*4+j] = SBOX[s[127-8*(((c+j)%4)*4+j) -: 8]];
    for (int c = 0; c < 4; c++) begin
      a0 = t[c*4]; a1 = t[c*4+1]; a2 = t[c*4+2]; a3 = t[c*4+3];
      al = a0 ^ a1 ^ a2 ^ a3;
      if (fin) begin
        o[127-32*c -: 32] = {a0, a1, a2, a3};
      end else begin
        o[127-32*c -: 32] = {a0 ^ al ^ xt(a0 ^ a1), a1 ^ al ^ xt(a1 ^ a2),
                             a2 ^ al ^ xt(a2 ^ a3), a3 ^ al ^ xt(a3 ^ a0)};
      end
    end
    return o;
  endfunction

  function automatic logic [127:0] key_next(input logic [127:0] rk, input logic [7:0] rc);
    logic [31:0] t, n0, n1, n2, n3;
    t  = {SBOX[rk[23:16]] ^ rc, SBOX[rk[15:8]], SBOX[rk[7:0]], SBOX[rk[31:24]]};
    n0 = rk[127:96] ^ t;
    n1 = rk[95:64] ^ n0;
    n2 = rk[63:32] ^ n1;
    n3 = rk[31:0] ^ n2;
    return {n0, n1, n2, n3};
  endfunction

  function automatic logic [127:0] gf_dbl(input logic [127:0] a);
    return {a[126:0], 1'b0} ^ (a[127] ? 128'h87 : 128'h0);
  endfunction

endpackage
`default_nettype wire

@@ rtl/acmac_front.sv @@
// Front end: packs header and message bytes into blocks and issues block requests.
`default_nettype none
module acmac_front (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      acc,
  input  wire logic [31:0]               msg_count,
  input  wire logic [4:0]                bearer_id,
  input  wire logic                      dir_bit,
  input  wire logic [63:0]               data_word,
  input  wire logic [3:0]                byte_count,
  input  wire logic                      first_item,
  input  wire logic                      last_item,
  output logic                           busy,
  output acmac_pkg::cmd_t                cmd,
  output logic                           cmd_valid,
  input  wire logic                      cmd_ready
);

  acmac_pkg::cmd_t pend_r [3];
  acmac_pkg::cmd_t pend_nxt [3];
  logic [1:0]   pend_cnt_r, pend_cnt_nxt;
  logic [127:0] buf_r, buf_nxt, held_r, held_nxt;
  logic [3:0]   cnt_r, cnt_nxt;
  logic         hv_r, hv_nxt, fresh_r, fresh_nxt;

  acmac_pkg::cmd_t lst [3];
  logic [1:0]   k;
  logic [3:0]   n, cnt_b;
  logic [63:0]  dmask, dat, hdr;
  logic [127:0] stream, buf_b, held_b, held1, pad;
  logic [255:0] wide;
  logic [4:0]   len, tot;
  logic         hv_b, hv1, fresh_b, done, fr;

  assign busy      = (pend_cnt_r != 2'd0);
  assign cmd_valid = busy;
  assign cmd       = pend_r[0];

  always_comb begin
    n      = (byte_count > 4'd8) ? 4'd8 : byte_count;
    dmask  = ~({64{1'b1}} >> {n, 3'b000});
    dat    = data_word & dmask;
    hdr    = {msg_count, bearer_id, dir_bit, 2'b00, 24'h0};
    stream = first_item ? {hdr, dat} : {dat, 64'h0};
    len    = first_item ? ({1'b0, n} + 5'd8) : {1'b0, n};
    cnt_b  = first_item ? 4'd0 : cnt_r;
    buf_b  = first_item ? 128'h0 : buf_r;
    held_b = held_r;
    hv_b   = first_item ? 1'b0 : hv_r;
    fresh_b = first_item ? 1'b1 : fresh_r;
    wide   = {buf_b, 128'h0} | ({stream, 128'h0} >> {cnt_b, 3'b000});
    tot    = {1'b0, cnt_b} + len;
    done   = tot[4];

    for (int i = 0; i < 3; i++) lst[i] = '0;
    k  = 2'd0;
    fr = fresh_b;
    if (done && hv_b) begin
      lst[k] = '{kind: acmac_pkg::CMD_CBC, fresh: fr, blk: held_b};
      k = k + 2'd1; fr = 1'b0;
    end
    held1   = done ? wide[255:128] : held_b;
    hv1     = done | hv_b;
    buf_nxt = done ? wide[127:0] : wide[255:128];
    cnt_nxt = tot[3:0];
    pad     = buf_nxt | ({8'h80, 120'h0} >> {cnt_nxt, 3'b000});
    held_nxt = held1;
    hv_nxt   = hv1;
    if (last_item) begin
      if (cnt_nxt == 4'd0 && hv1) begin
        lst[k] = '{kind: acmac_pkg::CMD_K1, fresh: fr, blk: held1};
        k = k + 2'd1;
      end else begin
        if (hv1) begin
          lst[k] = '{kind: acmac_pkg::CMD_CBC, fresh: fr, blk: held1};
          k = k + 2'd1; fr = 1'b0;
        end
        lst[k] = '{kind: acmac_pkg::CMD_K2, fresh: fr, blk: pad};
        k = k + 2'd1;
      end
      buf_nxt = 128'h0; cnt_nxt = 4'd0; hv_nxt = 1'b0; fr = 1'b1;
    end
    fresh_nxt = fr;

    // drain one request per cycle while cmd_ready is high
    pend_nxt     = pend_r;
    pend_cnt_nxt = pend_cnt_r;
    if (acc) begin
      pend_nxt     = lst;
      pend_cnt_nxt = k;
    end else if (busy && cmd_ready) begin
      pend_nxt[0]  = pend_r[1];
      pend_nxt[1]  = pend_r[2];
      pend_cnt_nxt = pend_cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    pend_r <= pend_nxt;
    if (acc) begin
      held_r <= held_nxt;
    end
    if (!rst_n) begin
      pend_cnt_r <= 2'd0;
      buf_r      <= 128'h0;
      cnt_r      <= 4'd0;
      hv_r       <= 1'b0;
      fresh_r    <= 1'b1;
    end else begin
      pend_cnt_r <= pend_cnt_nxt;
      if (acc) begin
        buf_r   <= buf_nxt;
        cnt_r   <= cnt_nxt;
        hv_r    <= hv_nxt;
        fresh_r <= fresh_nxt;
      end
    end
  end

endmodule
`default_nettype wire

@@ rtl/acmac_back.sv @@
// Back end: iterative AES-128 (one round per cycle), subkey derivation, CBC chain.
`default_nettype none
module acmac_back (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic [127:0]      key,
  input  wire logic              key_wr,
  input  wire acmac_pkg::cmd_t   cmd,
  input  wire logic              cmd_valid,
  output logic                   cmd_ready,
  input  wire logic              out_space,
  output logic                   tag_valid,
  output logic [31:0]            tag
);

  localparam logic [1:0] JOB_KEY = 2'd0;
  localparam logic [1:0] JOB_CBC = 2'd1;
  localparam logic [1:0] JOB_FIN = 2'd2;

  logic         busy_r, need_r;
  logic [1:0]   job_r;
  logic [3:0]   round_r;
  logic [7:0]   rcon_r;
  logic [127:0] st_r, rk_r, chain_r, k1_r, k2_r;
  logic [127:0] nrk, res, x, sk;
  logic         fin, start_key;

  assign start_key = !busy_r && need_r;
  assign cmd_ready = !busy_r && !need_r && (cmd.kind == acmac_pkg::CMD_CBC || out_space);
  assign fin       = busy_r && (round_r == 4'd10);
  assign nrk       = acmac_pkg::key_next(rk_r, rcon_r);
  assign res       = acmac_pkg::aes_round(st_r, round_r == 4'd10) ^ nrk;
  assign tag_valid = fin && (job_r == JOB_FIN);
  assign tag       = res[127:96];

  always_comb begin
    unique case (cmd.kind)
      acmac_pkg::CMD_K1: sk = k1_r;
      acmac_pkg::CMD_K2: sk = k2_r;
      default:           sk = 128'h0;
    endcase
    x = (cmd.fresh ? 128'h0 : chain_r) ^ cmd.blk ^ sk;
  end

  always_ff @(posedge clk) begin
    if (start_key || (cmd_valid && cmd_ready)) begin
      st_r    <= start_key ? key : (x ^ key);
      rk_r    <= key;
      rcon_r  <= 8'h01;
      round_r <= 4'd1;
    end else if (busy_r) begin
      st_r    <= res;
      rk_r    <= nrk;
      rcon_r  <= acmac_pkg::xt(rcon_r);
      round_r <= round_r + 4'd1;
    end
    if (fin && job_r == JOB_CBC) begin
      chain_r <= res;
    end
    if (!rst_n) begin
      busy_r <= 1'b0;
      need_r <= 1'b1;
      job_r  <= JOB_KEY;
      k1_r   <= 128'h0;
      k2_r   <= 128'h0;
    end else begin
      if (key_wr) begin
        need_r <= 1'b1;
      end else if (start_key) begin
        need_r <= 1'b0;
      end
      if (start_key) begin
        busy_r <= 1'b1;
        job_r  <= JOB_KEY;
      end else if (cmd_valid && cmd_ready) begin
        busy_r <= 1'b1;
        job_r  <= (cmd.kind == acmac_pkg::CMD_CBC) ? JOB_CBC : JOB_FIN;
      end else if (fin) begin
        busy_r <= 1'b0;
      end
      if (fin && job_r == JOB_KEY) begin
        k1_r <= acmac_pkg::gf_dbl(res);
        k2_r <= acmac_pkg::gf_dbl(acmac_pkg::gf_dbl(res));
      end
    end
  end

endmodule
`default_nettype wire

@@ rtl/aes_cmac_integrity_tag_core.sv @@
// Top level: key registers, request queue between front and back, tag queue.
// Each 16-byte block (header included) passes through the iterative AES unit, which sets
// throughput; an item completing no block is taken every cycle while no request is pending.
// The tag follows the last item once each block it releases (1 to 3) has passed through AES.
// A key write rederives the subkeys before requests resume.
// Synchronous active-low reset clears the message state and derives subkeys of the zero key.
`default_nettype none
module aes_cmac_integrity_tag_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_push,
  output logic             in_full,
  input  wire logic [31:0] in_msg_count,
  input  wire logic [4:0]  in_bearer_id,
  input  wire logic        in_dir_bit,
  input  wire logic [63:0] in_data_word,
  input  wire logic [3:0]  in_byte_count,
  input  wire logic        in_first_item,
  input  wire logic        in_last_item,
  output logic             out_empty,
  input  wire logic        out_pop,
  output logic [31:0]      out_mac_tag,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_index,
  input  wire logic [63:0] cfg_data
);

  logic [63:0]     key_hi_r, key_lo_r;
  logic            cfg_wr, acc;
  acmac_pkg::cmd_t f_cmd, q0_r, q1_r;
  logic            f_valid, f_ready, f_busy;
  logic [1:0]      qcnt_r, ocnt_r;
  logic            q_push, q_pop, b_ready, t_valid, o_pop;
  logic [31:0]     t_tag, o0_r, o1_r;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;
  assign acc       = in_push && !in_full;
  assign in_full   = f_busy;

  acmac_front u_front (
    .clk, .rst_n, .acc,
    .msg_count (in_msg_count), .bearer_id (in_bearer_id), .dir_bit (in_dir_bit),
    .data_word (in_data_word), .byte_count (in_byte_count),
    .first_item (in_first_item), .last_item (in_last_item),
    .busy (f_busy), .cmd (f_cmd), .cmd_valid (f_valid), .cmd_ready (f_ready)
  );

  // two-entry request queue
  assign f_ready = (qcnt_r != 2'd2);
  assign q_push  = f_valid && f_ready;
  assign q_pop   = (qcnt_r != 2'd0) && b_ready;

  acmac_back u_back (
    .clk, .rst_n,
    .key ({key_hi_r, key_lo_r}), .key_wr (cfg_wr),
    .cmd (q0_r), .cmd_valid (qcnt_r != 2'd0), .cmd_ready (b_ready),
    .out_space (ocnt_r != 2'd2),
    .tag_valid (t_valid), .tag (t_tag)
  );

  assign out_empty   = (ocnt_r == 2'd0);
  assign out_mac_tag = o0_r;
  assign o_pop       = out_pop && !out_empty;

  always_ff @(posedge clk) begin
    if (q_pop) begin
      q0_r <= (qcnt_r == 2'd2) ? q1_r : f_cmd;
      if (q_push && qcnt_r == 2'd2) q1_r <= f_cmd;
    end else if (q_push) begin
      if (qcnt_r == 2'd0) q0_r <= f_cmd;
      else q1_r <= f_cmd;
    end
    if (o_pop) begin
      o0_r <= (ocnt_r == 2'd2) ? o1_r : t_tag;
      if (t_valid && ocnt_r == 2'd2) o1_r <= t_tag;
    end else if (t_valid) begin
      if (ocnt_r == 2'd0) o0_r <= t_tag;
      else o1_r <= t_tag;
    end
    if (!rst_n) begin
      key_hi_r <= 64'h0;
      key_lo_r <= 64'h0;
      qcnt_r   <= 2'd0;
      ocnt_r   <= 2'd0;
    end else begin
      if (cfg_wr && cfg_index == acmac_pkg::CFG_KEY_HIGH) key_hi_r <= cfg_data;
      if (cfg_wr && cfg_index == acmac_pkg::CFG_KEY_LOW)  key_lo_r <= cfg_data;
      qcnt_r <= qcnt_r + {1'b0, q_push} - {1'b0, q_pop};
      ocnt_r <= ocnt_r + {1'b0, t_valid} - {1'b0, o_pop};
    end
  end

endmodule
`default_nettype wire

@@ rtl/acmac_checker.sv @@
// Port-level checker for the CMAC tag core, bound to the top level.
`default_nettype none
module acmac_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_full,
  input wire logic        out_empty,
  input wire logic        out_pop,
  input wire logic [31:0] out_mac_tag,
  input wire logic        cfg_ready
);

  a_empty_after_reset: assert property (@(posedge clk) !rst_n |=> out_empty)
    else $error("result queue not empty after reset");

  a_open_after_reset: assert property (@(posedge clk) !rst_n |=> !in_full)
    else $error("input full right after reset");

  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n) cfg_ready)
    else $error("configuration port not ready");

  a_tag_held: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> (!out_empty && $stable(out_mac_tag)))
    else $error("waiting tag lost or changed");

endmodule

bind aes_cmac_integrity_tag_core acmac_checker u_acmac_checker (
  .clk, .rst_n, .in_full, .out_empty, .out_pop, .out_mac_tag, .cfg_ready
);
`default_nettype wire

@@ tb/aes_cmac_integrity_tag_core_test.sv @@
// Self-checking testbench for the 128-EIA2 AES-CMAC integrity tag core.
`default_nettype none
module aes_cmac_integrity_tag_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [31:0] cnt;
    logic [4:0]  bearer;
    logic        dir;
    logic [63:0] data;
    logic [3:0]  nbytes;
    logic        first;
    logic        last;
  } msg_item_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_push = 1'b0;
  logic        in_full;
  logic [31:0] in_msg_count = '0;
  logic [4:0]  in_bearer_id = '0;
  logic        in_dir_bit = 1'b0;
  logic [63:0] in_data_word = '0;
  logic [3:0]  in_byte_count = '0;
  logic        in_first_item = 1'b0;
  logic        in_last_item = 1'b0;
  logic        out_empty;
  logic        out_pop = 1'b0;
  logic [31:0] out_mac_tag;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = acmac_pkg::CFG_KEY_HIGH;
  logic [63:0] cfg_data = '0;

  aes_cmac_integrity_tag_core uut (.*);

  always #4 clk = ~clk;

  msg_item_t   pending[$];
  logic [31:0] tags_due[$];
  int          errors = 0;
  int          n_taken = 0;
  int          n_cfg = 0;
  bit          quiet = 0;
  bit          hold_off = 0;

  // tag model state
  logic [127:0] key, k1, k2, chain, fill, held;
  int           nfill;
  bit           held_ok;

  function automatic logic [127:0] aes_enc(logic [127:0] k, logic [127:0] p);
    logic [7:0] w[176];
    logic [7:0] s[16];
    logic [7:0] t[16];
    logic [7:0] tw[4];
    logic [7:0] f, rc, a0, a1, a2, a3, al;
    logic [127:0] o;
    rc = 8'h01;
    for (int i = 0; i < 16; i++) w[i] = k[127-8*i -: 8];
    for (int i = 16; i < 176; i += 4) begin
      for (int j = 0; j < 4; j++) tw[j] = w[i-4+j];
      if (i % 16 == 0) begin
        f = tw[0];
        tw[0] = acmac_pkg::SBOX[tw[1]] ^ rc;
        tw[1] = acmac_pkg::SBOX[tw[2]];
        tw[2] = acmac_pkg::SBOX[tw[3]];
        tw[3] = acmac_pkg::SBOX[f];
        rc = {rc[6:0], 1'b0} ^ (rc[7] ? 8'h1b : 8'h00);
      end
      for (int j = 0; j < 4; j++) w[i+j] = w[i-16+j] ^ tw[j];
    end
    for (int i = 0; i < 16; i++) s[i] = p[127-8*i -: 8] ^ w[i];
    for (int r = 1; r <= 10; r++) begin
      for (int c = 0; c < 4; c++)
        for (int j = 0; j < 4; j++) t[c*4+j] = acmac_pkg::SBOX[s[((c+j)%4)*4+j]];
      for (int c = 0; c < 4; c++) begin
        a0 = t[c*4]; a1 = t[c*4+1]; a2 = t[c*4+2]; a3 = t[c*4+3];
        if (r == 10) begin
          s[c*4] = a0; s[c*4+1] = a1; s[c*4+2] = a2; s[c*4+3] = a3;
        end else begin
          al = a0 ^ a1 ^ a2 ^ a3;
          s[c*4]   = a0 ^ al ^ xdbl(a0 ^ a1);
          s[c*4+1] = a1 ^ al ^ xdbl(a1 ^ a2);
          s[c*4+2] = a2 ^ al ^ xdbl(a2 ^ a3);
          s[c*4+3] = a3 ^ al ^ xdbl(a3 ^ a0);
        end
      end
      for (int i = 0; i < 16; i++) s[i] ^= w[r*16+i];
    end
    for (int i = 0; i < 16; i++) o[127-8*i -: 8] = s[i];
    return o;
  endfunction

  function automatic logic [7:0] xdbl(logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [127:0] gf_times2(logic [127:0] a);
    return {a[126:0], 1'b0} ^ (a[127] ? 128'h87 : 128'h0);
  endfunction

  function automatic void rekey();
    k1 = gf_times2(aes_enc(key, '0));
    k2 = gf_times2(k1);
  endfunction

  function automatic void drop_message();
    chain = '0; fill = '0; held = '0; nfill = 0; held_ok = 0;
  endfunction

  function automatic void absorb(logic [7:0] b);
    fill[127-8*nfill -: 8] = b;
    nfill++;
    if (nfill == 16) begin
      if (held_ok) chain = aes_enc(key, chain ^ held);
      held = fill; held_ok = 1; fill = '0; nfill = 0;
    end
  endfunction

  function automatic void predict_tag(msg_item_t it);
    int n;
    logic [127:0] fin;
    if (it.first) begin
      drop_message();
      for (int i = 0; i < 4; i++) absorb(it.cnt[31-8*i -: 8]);
      absorb({it.bearer, it.dir, 2'b00});
      repeat (3) absorb(8'h00);
    end
    n = (it.nbytes > 8) ? 8 : it.nbytes;
    for (int i = 0; i < n; i++) absorb(it.data[63-8*i -: 8]);
    if (!it.last) return;
    if (nfill == 0 && held_ok) begin
      fin = held ^ k1;
    end else begin
      if (held_ok) chain = aes_enc(key, chain ^ held);
      fin = fill;
      fin[127-8*nfill -: 8] = 8'h80;
      fin ^= k2;
    end
    chain = aes_enc(key, chain ^ fin);
    tags_due.push_back(chain[127:96]);
    drop_message();
  endfunction

  // request driver
  always @(negedge clk) begin
    if (rst_n && pending.size() > 0 && (quiet || $urandom_range(99) >= 9)) begin
      in_push       <= 1'b1;
      in_msg_count  <= pending[0].cnt;
      in_bearer_id  <= pending[0].bearer;
      in_dir_bit    <= pending[0].dir;
      in_data_word  <= pending[0].data;
      in_byte_count <= pending[0].nbytes;
      in_first_item <= pending[0].first;
      in_last_item  <= pending[0].last;
    end else begin
      in_push <= 1'b0;
    end
    out_pop <= rst_n && !hold_off && (quiet || $urandom_range(99) >= 9);
  end

  always @(posedge clk) begin
    if (in_push && !in_full) begin
      predict_tag(pending.pop_front());
      n_taken <= n_taken + 1;
    end
    if (cfg_valid && cfg_ready) begin
      if (cfg_index == acmac_pkg::CFG_KEY_HIGH) key[127:64] = cfg_data;
      else key[63:0] = cfg_data;
      rekey();
      n_cfg <= n_cfg + 1;
    end
  end

  // tag monitor
  always @(posedge clk) begin
    if (out_pop && !out_empty) begin
      if (tags_due.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected tag %h", out_mac_tag);
      end else begin
        if (out_mac_tag !== tags_due[0]) begin
          errors++;
          if (errors <= 10)
            $display("mac_tag mismatch: expected %h actual %h", tags_due[0], out_mac_tag);
        end
        void'(tags_due.pop_front());
      end
    end
  end

  function automatic void add(logic [31:0] c, logic [4:0] b, logic d, logic [63:0] w,
                              logic [3:0] n, logic f, logic l);
    msg_item_t it;
    it.cnt = c; it.bearer = b; it.dir = d; it.data = w; it.nbytes = n;
    it.first = f; it.last = l;
    pending.push_back(it);
  endfunction

  function automatic logic [3:0] rand_len();
    int r;
    r = $urandom_range(99);
    if (r < 6) return 4'd0;
    if (r < 11) return 4'($urandom_range(15, 9));
    if (r < 45) return 4'd8;
    return 4'($urandom_range(8, 1));
  endfunction

  function automatic void add_random(int target);
    int r, k;
    int done;
    done = 0;
    while (done < target) begin
      r = $urandom_range(99);
      k = ($urandom_range(9) == 0) ? $urandom_range(12, 5) : $urandom_range(4, 1);
      for (int i = 0; i < k; i++)
        add($urandom, 5'($urandom), 1'($urandom), {$urandom, $urandom}, rand_len(),
            (r < 90) ? (i == 0) : ($urandom_range(3) == 0),
            (r < 80) ? (i == k - 1) : (r < 90 ? $urandom_range(3) == 0 : 1'b0));
      done += k;
    end
  endfunction

  task automatic write_key(logic idx, logic [63:0] v);
    int n0;
    n0 = n_cfg;
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    do @(negedge clk); while (n_cfg == n0);
    cfg_valid <= 1'b0;
  endtask

  // blocks of an unfinished message may still be in the cipher after the last tag
  task automatic drain();
    do @(negedge clk); while (pending.size() != 0 || tags_due.size() != 0);
    repeat (100) @(negedge clk);
  endtask

  initial begin
    key = '0;
    rekey();
    drop_message();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: header extremes, empty message, block boundaries, odd counts
    add(32'h0, 5'd0, 1'b0, 64'h0, 4'd0, 1'b1, 1'b1);
    add(32'hffffffff, 5'd31, 1'b1, {64{1'b1}}, 4'd8, 1'b1, 1'b1);
    add(32'h12345678, 5'd21, 1'b0, 64'hfedcba9876543210, 4'd3, 1'b1, 1'b1);
    add(32'h1, 5'd1, 1'b1, 64'h0123456789abcdef, 4'd8, 1'b1, 1'b0);
    add(32'h0, 5'd0, 1'b0, 64'haaaaaaaa55555555, 4'd8, 1'b0, 1'b0);
    add(32'h0, 5'd0, 1'b0, 64'h5555555555555555, 4'd8, 1'b0, 1'b1);
    add(32'h80000000, 5'd16, 1'b0, 64'hffffffffffffffff, 4'd15, 1'b1, 1'b0);
    add(32'h0, 5'd0, 1'b0, 64'h0, 4'd0, 1'b0, 1'b1);
    add(32'h0, 5'd0, 1'b0, 64'h1122334455667788, 4'd9, 1'b0, 1'b1);
    add(32'h0, 5'd0, 1'b0, 64'h0, 4'd0, 1'b0, 1'b1);
    add(32'hdeadbeef, 5'd7, 1'b1, 64'h0102030405060708, 4'd5, 1'b1, 1'b0);
    add(32'hcafef00d, 5'd9, 1'b0, 64'h0807060504030201, 4'd7, 1'b1, 1'b0);
    add(32'h0, 5'd0, 1'b0, 64'h0, 4'd0, 1'b0, 1'b1);
    add(32'h0, 5'd0, 1'b0, 64'hffffffffffffffff, 4'd8, 1'b0, 1'b0);
    add(32'h0, 5'd0, 1'b0, 64'h8000000000000001, 4'd1, 1'b0, 1'b1);
    add(32'h7fffffff, 5'd30, 1'b1, 64'h0, 4'd8, 1'b1, 1'b0);
    add(32'h0, 5'd0, 1'b0, 64'h0, 4'd8, 1'b0, 1'b0);
    add(32'h0, 5'd0, 1'b0, 64'hffffffffffffffff, 4'd8, 1'b0, 1'b1);
    drain();

    write_key(acmac_pkg::CFG_KEY_HIGH, {64{1'b1}});
    write_key(acmac_pkg::CFG_KEY_LOW, {64{1'b1}});
    add_random(260);
    // leave a message open across the key change
    add(32'h2468ace0, 5'd3, 1'b1, {$urandom, $urandom}, 4'd8, 1'b1, 1'b0);
    drain();

    write_key(acmac_pkg::CFG_KEY_HIGH, 64'h2b7e151628aed2a6);
    write_key(acmac_pkg::CFG_KEY_LOW, 64'habf7158809cf4f3c);
    add({$urandom, $urandom}, 5'd0, 1'b0, {$urandom, $urandom}, 4'd6, 1'b0, 1'b1);
    quiet = 1;
    add_random(260);
    drain();
    quiet = 0;

    write_key(acmac_pkg::CFG_KEY_HIGH, 64'h0);
    write_key(acmac_pkg::CFG_KEY_LOW, {64{1'b1}});
    add_random(260);
    drain();

    for (int p = 0; p < 2; p++) begin
      write_key(acmac_pkg::CFG_KEY_HIGH, {$urandom, $urandom});
      write_key(acmac_pkg::CFG_KEY_LOW, {$urandom, $urandom});
      add_random(260);
      drain();
    end

    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // tag receiver stops long enough for the block to back up
  initial begin
    do @(negedge clk); while (n_taken < 400);
    hold_off = 1;
    repeat (700) @(negedge clk);
    hold_off = 0;
  end

  initial begin
    #4ms;
    $display("== FAIL ==");
    $finish;
  end

endmodule
`default_nettype wire
